// ===== design/acf_pkg.sv =====
// Package: shared types, color codes and a helper function for the artifact color fix-up
`timescale 1ns / 1ps
package acf_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef logic [1:0] color_t;

  localparam color_t SrcBlack  = 2'd0;
  localparam color_t SrcBlue   = 2'd1;
  localparam color_t SrcOrange = 2'd2;
  localparam color_t SrcWhite  = 2'd3;

  typedef struct packed {
    color_t left_color;
    color_t right_color;
    logic   row_done;
    logic   last_for_input;
  } result_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
  } push_t;

  function automatic color_t to_code(color_t src, logic phase);
    color_t code;
    code = src;
    if (phase && (src == SrcBlue || src == SrcOrange)) begin
      code = src ^ SrcWhite;
    end
    return code;
  endfunction

endpackage

// ===== design/acf_in_if.sv =====
// Interface: input channel carrying one source bit pair per transfer
`timescale 1ns / 1ps
interface acf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] bit_pair;
  logic       row_end;

  modport source (output valid, output bit_pair, output row_end, input ready);
  modport sink   (input valid, input bit_pair, input row_end, output ready);
endinterface

// ===== design/acf_out_if.sv =====
// Interface: output channel carrying one fixed-up pixel pair per transfer
`timescale 1ns / 1ps
interface acf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] left_color;
  logic [1:0] right_color;
  logic       row_done;
  logic       last_for_input;

  modport source (output valid, output left_color, output right_color, output row_done,
                  output last_for_input, input ready);
  modport sink   (input valid, input left_color, input right_color, input row_done,
                  input last_for_input, output ready);
endinterface

// ===== design/acf_fixup.sv =====
// Fix-up stage: holds one pair, applies the artifact color rules, forms up to two results
`timescale 1ns / 1ps
module acf_fixup
  import acf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cfg_we_i,
  input  logic    cfg_wdata_i,
  input  logic    in_fire_i,
  input  color_t  bit_pair_i,
  input  logic    row_end_i,
  output push_t   push_o,
  output result_t res_a_o,
  output result_t res_b_o
);

  logic   color_phase_q;
  color_t held_base_q;
  logic   held_valid_q;
  logic   held_is_first_q;
  color_t prior_right_q;

  color_t left_a, right_a, left_b, right_b, prior_b;

  always_comb begin
    left_a  = held_base_q;
    right_a = held_base_q;
    if (held_base_q == SrcBlue) begin
      if (bit_pair_i == SrcOrange || bit_pair_i == SrcWhite) begin
        left_a  = SrcBlack;
        right_a = SrcWhite;
      end
    end else if (held_base_q == SrcOrange && !held_is_first_q) begin
      if (prior_right_q == SrcBlue || prior_right_q == SrcWhite) begin
        left_a  = SrcWhite;
        right_a = SrcBlack;
      end
    end

    prior_b = held_valid_q ? right_a : prior_right_q;
    left_b  = bit_pair_i;
    right_b = bit_pair_i;
    if (bit_pair_i == SrcOrange && held_valid_q) begin
      if (prior_b == SrcBlue || prior_b == SrcWhite) begin
        left_b  = SrcWhite;
        right_b = SrcBlack;
      end
    end
  end

  assign push_o.push_a = in_fire_i && held_valid_q;
  assign push_o.push_b = in_fire_i && row_end_i;

  assign res_a_o.left_color     = to_code(left_a, color_phase_q);
  assign res_a_o.right_color    = to_code(right_a, color_phase_q);
  assign res_a_o.row_done       = 1'b0;
  assign res_a_o.last_for_input = !row_end_i;

  assign res_b_o.left_color     = to_code(left_b, color_phase_q);
  assign res_b_o.right_color    = to_code(right_b, color_phase_q);
  assign res_b_o.row_done       = 1'b1;
  assign res_b_o.last_for_input = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_phase_q   <= 1'b0;
      held_base_q     <= SrcBlack;
      held_valid_q    <= 1'b0;
      held_is_first_q <= 1'b0;
      prior_right_q   <= SrcBlack;
    end else begin
      if (cfg_we_i) begin
        color_phase_q <= cfg_wdata_i;
      end
      if (in_fire_i) begin
        if (row_end_i) begin
          prior_right_q   <= right_b;
          held_base_q     <= SrcBlack;
          held_valid_q    <= 1'b0;
          held_is_first_q <= 1'b0;
        end else begin
          if (held_valid_q) begin
            prior_right_q <= right_a;
          end
          held_base_q     <= bit_pair_i;
          held_valid_q    <= 1'b1;
          held_is_first_q <= !held_valid_q;
        end
      end
    end
  end

endmodule

// ===== design/acf_result_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per transfer
`timescale 1ns / 1ps
module acf_result_fifo
  import acf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  result_t res_a_i,
  input  result_t res_b_i,
  output logic    room_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  result_t             mem_q [FifoDepth];
  logic    [PtrW-1:0]  wptr_q, rptr_q;
  logic    [CntW-1:0]  count_q;
  logic                pop;
  logic    [PtrW-1:0]  wptr_b;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign room_o  = (count_q <= CntW'(FifoDepth - 2));
  assign data_o  = mem_q[rptr_q];
  assign wptr_b  = wptr_q + PtrW'(push_i.push_a);

  always_ff @(posedge clk_i) begin
    if (push_i.push_a) begin
      mem_q[wptr_q] <= res_a_i;
    end
    if (push_i.push_b) begin
      mem_q[wptr_b] <= res_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + PtrW'(push_i.push_a) + PtrW'(push_i.push_b);
      rptr_q  <= rptr_q + PtrW'(pop);
      count_q <= count_q + CntW'(push_i.push_a) + CntW'(push_i.push_b) - CntW'(pop);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(FifoDepth))
    else $error("result queue count out of range");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.push_a || push_i.push_b) |-> count_q <= CntW'(FifoDepth - 2))
    else $error("push into queue without room");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i.push_a && !push_i.push_b) |=> count_q == $past(count_q) - CntW'(1))
    else $error("queue count did not drop on transfer");
`endif

endmodule

// ===== design/artifact_color_crt_fixup.sv =====
// Latency: a pair's result is queued one input transfer later, or on its own row_end transfer.
// A result is visible at the output once it is written to the queue and reaches its head.
// Throughput: one input transfer per cycle while the four-entry result queue has room
// for two results; a row_end transfer with a held pair adds one result.
// Reset: asynchronous, active low; clears held pair, phase and queue.
// Top level: artifact color decoder with CRT fix-up
`timescale 1ns / 1ps
module artifact_color_crt_fixup
  import acf_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  acf_in_if.sink        in_ch,
  acf_out_if.source     out_ch
);

  push_t   push;
  result_t res_a, res_b, res_out;
  logic    room;
  logic    in_fire;

  assign in_ch.ready = room;
  assign in_fire     = in_ch.valid && room;

  acf_fixup u_fixup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .bit_pair_i  (in_ch.bit_pair),
    .row_end_i   (in_ch.row_end),
    .push_o      (push),
    .res_a_o     (res_a),
    .res_b_o     (res_b)
  );

  acf_result_fifo u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_a_i (res_a),
    .res_b_i (res_b),
    .room_o  (room),
    .valid_o (out_ch.valid),
    .ready_i (out_ch.ready),
    .data_o  (res_out)
  );

  assign out_ch.left_color     = res_out.left_color;
  assign out_ch.right_color    = res_out.right_color;
  assign out_ch.row_done       = res_out.row_done;
  assign out_ch.last_for_input = res_out.last_for_input;

endmodule
